// ===== rtl/ult_pkg.sv =====
// Package for the unordered list table: transaction payload types, command and
// status codes, and the control store of the sequencer.
// No dependencies; compiled first.
package ult_pkg;

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Fixed field widths of the result transaction
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  // Sequencer step addresses
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] S_WAIT   = 3'd0;
  localparam logic [PC_W-1:0] S_INSERT = 3'd1;
  localparam logic [PC_W-1:0] S_CHECK  = 3'd2;
  localparam logic [PC_W-1:0] S_SCAN   = 3'd3;
  localparam logic [PC_W-1:0] S_RDLAST = 3'd4;
  localparam logic [PC_W-1:0] S_MOVE   = 3'd5;
  localparam logic [PC_W-1:0] S_POST   = 3'd6;

  // Datapath operations
  localparam logic [2:0] OP_WAIT   = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_CHECK  = 3'd2;
  localparam logic [2:0] OP_SCAN   = 3'd3;
  localparam logic [2:0] OP_RDLAST = 3'd4;
  localparam logic [2:0] OP_MOVE   = 3'd5;
  localparam logic [2:0] OP_POST   = 3'd6;

  // Hold conditions: the step repeats while the condition is true
  localparam logic [1:0] HOLD_NONE   = 2'd0;
  localparam logic [1:0] HOLD_ACCEPT = 2'd1;  // no command taken yet
  localparam logic [1:0] HOLD_SCAN   = 2'd2;  // scan not finished
  localparam logic [1:0] HOLD_OUT    = 2'd3;  // result register occupied

  // Branch conditions
  localparam logic [2:0] BR_NEVER    = 3'd0;
  localparam logic [2:0] BR_ALWAYS   = 3'd1;
  localparam logic [2:0] BR_DISPATCH = 3'd2;  // target from command code
  localparam logic [2:0] BR_EMPTY    = 3'd3;
  localparam logic [2:0] BR_SCANEXIT = 3'd4;  // scan over, nothing to move

  typedef struct packed {
    logic [2:0]      op;
    logic [1:0]      hold;
    logic [2:0]      br;
    logic [PC_W-1:0] target;
  } uc_word_t;

  // Control store
  function automatic uc_word_t uc_rom(input logic [PC_W-1:0] pc);
    uc_word_t w;
    w = '{op: OP_POST, hold: HOLD_NONE, br: BR_ALWAYS, target: S_WAIT};
    unique case (pc)
      S_WAIT:   w = '{op: OP_WAIT,   hold: HOLD_ACCEPT, br: BR_DISPATCH, target: S_WAIT};
      S_INSERT: w = '{op: OP_INSERT, hold: HOLD_NONE,   br: BR_ALWAYS,   target: S_POST};
      S_CHECK:  w = '{op: OP_CHECK,  hold: HOLD_NONE,   br: BR_EMPTY,    target: S_POST};
      S_SCAN:   w = '{op: OP_SCAN,   hold: HOLD_SCAN,   br: BR_SCANEXIT, target: S_POST};
      S_RDLAST: w = '{op: OP_RDLAST, hold: HOLD_NONE,   br: BR_NEVER,    target: S_WAIT};
      S_MOVE:   w = '{op: OP_MOVE,   hold: HOLD_NONE,   br: BR_NEVER,    target: S_WAIT};
      S_POST:   w = '{op: OP_POST,   hold: HOLD_OUT,    br: BR_ALWAYS,   target: S_WAIT};
      default:  w = '{op: OP_POST,   hold: HOLD_NONE,   br: BR_ALWAYS,   target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/ult_stream_if.sv =====
// Valid/ready channel for the unordered list table, one transaction per
// handshake. Payload type is given at instantiation (see ult_pkg).
interface ult_stream_if #(parameter type payload_t = logic);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/unordered_list_table.sv =====
// Unordered list table: holds up to CAPACITY 32-bit words; commands insert
// (append), search (first bit-exact match) and remove (swap last entry into
// the vacated slot). One result per command. Commands are taken one at a time
// by a microcoded sequencer; the memory has one read port and returns one
// entry per cycle, which sets the scan rate. A search scans from slot 0 to
// the first match or the last entry and skips the scan on an empty list;
// a successful remove then moves the last entry in; an unused command goes
// straight to the result step. The result sits in an output register, so
// the next command is taken while a result waits; that command's result
// step then stalls until the register drains. No clearing pass.
// Depends on ult_pkg and ult_stream_if.
module unordered_list_table #(
  parameter int CAPACITY = 16
) (
  input logic   clk,
  input logic   rst,
  ult_stream_if.sink   cmd,
  ult_stream_if.source rsp
);
  import ult_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Sequencer
  logic [PC_W-1:0] pc, pc_next;
  uc_word_t        uc;

  // Datapath registers
  logic [1:0]       cmd_reg, cmd_reg_next;
  logic [31:0]      key, key_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             rd_vld, rd_vld_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic [1:0]       status, status_next;
  logic             rsp_valid, rsp_valid_next;
  rsp_t             rsp_data, rsp_data_next;

  // Memory
  logic [31:0]      mem [CAPACITY];
  logic [31:0]      rdata;
  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  logic [31:0]      wdata;

  // Status terms
  logic             accept, hit, scan_last, scan_done, out_free, full;
  logic [CNT_W-1:0] cnt_m1;
  logic             hold_now, br_now;
  logic [PC_W-1:0]  br_target;

  assign uc        = uc_rom(pc);
  assign cmd.ready = (uc.op == OP_WAIT);
  assign accept    = cmd.valid && cmd.ready;
  assign cnt_m1    = count - CNT_W'(1);
  assign full      = (count == CNT_W'(CAPACITY));
  assign hit       = rd_vld && (rdata == key);
  assign scan_last = rd_vld && (CNT_W'(rd_idx) == cnt_m1);
  assign scan_done = hit || scan_last;
  assign out_free  = !rsp_valid || rsp.ready;

  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;

  // Hold and branch decode
  always_comb begin
    unique case (uc.hold)
      HOLD_NONE:   hold_now = 1'b0;
      HOLD_ACCEPT: hold_now = !accept;
      HOLD_SCAN:   hold_now = !scan_done;
      HOLD_OUT:    hold_now = !out_free;
      default:     hold_now = 1'b0;
    endcase

    br_target = uc.target;
    case (cmd.payload.command) inside
      CMD_INSERT:                    br_target = S_INSERT;
      CMD_SEARCH, CMD_REMOVE:        br_target = S_CHECK;
      default:                       br_target = S_POST;
    endcase
    if (uc.br != BR_DISPATCH) begin
      br_target = uc.target;
    end

    unique case (uc.br)
      BR_NEVER:    br_now = 1'b0;
      BR_ALWAYS:   br_now = 1'b1;
      BR_DISPATCH: br_now = 1'b1;
      BR_EMPTY:    br_now = (count == '0);
      BR_SCANEXIT: br_now = !hit || (cmd_reg != CMD_REMOVE);
      default:     br_now = 1'b0;
    endcase

    if (hold_now) begin
      pc_next = pc;
    end else if (br_now) begin
      pc_next = br_target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  // Datapath control
  always_comb begin
    cmd_reg_next   = cmd_reg;
    key_next       = key;
    count_next     = count;
    idx_next       = idx;
    rd_vld_next    = rd_vld;
    rd_idx_next    = rd_idx;
    pos_next       = pos;
    status_next    = status;
    rsp_valid_next = rsp_valid && !rsp.ready;
    rsp_data_next  = rsp_data;
    we             = 1'b0;
    re             = 1'b0;
    waddr          = pos;
    wdata          = rdata;
    raddr          = idx[IDX_W-1:0];

    unique case (uc.op)
      OP_WAIT: begin
        if (accept) begin
          cmd_reg_next = cmd.payload.command;
          key_next     = cmd.payload.value;
          status_next  = ST_NOTFOUND;
          pos_next     = '0;
        end
      end
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          we          = 1'b1;
          waddr       = count[IDX_W-1:0];
          wdata       = key;
          pos_next    = count[IDX_W-1:0];
          count_next  = count + CNT_W'(1);
          status_next = ST_OK;
        end
      end
      OP_CHECK: begin
        idx_next    = '0;
        rd_vld_next = 1'b0;
        if (count == '0 && cmd_reg == CMD_REMOVE) begin
          status_next = ST_EMPTY;
        end
      end
      OP_SCAN: begin
        // compare the entry read last cycle, issue the next read
        if (hit) begin
          pos_next    = rd_idx;
          status_next = ST_OK;
        end
        if (!scan_done && idx < count) begin
          re          = 1'b1;
          rd_vld_next = 1'b1;
          rd_idx_next = idx[IDX_W-1:0];
          idx_next    = idx + CNT_W'(1);
        end else begin
          rd_vld_next = 1'b0;
        end
      end
      OP_RDLAST: begin
        re    = 1'b1;
        raddr = cnt_m1[IDX_W-1:0];
      end
      OP_MOVE: begin
        we         = 1'b1;
        waddr      = pos;
        wdata      = rdata;
        count_next = cnt_m1;
      end
      OP_POST: begin
        if (out_free) begin
          rsp_valid_next         = 1'b1;
          rsp_data_next.status   = status;
          rsp_data_next.position = POS_W'(pos);
          rsp_data_next.count    = COUNT_W'(count);
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= S_WAIT;
      count     <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      pc        <= pc_next;
      count     <= count_next;
      rd_vld    <= rd_vld_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_reg  <= cmd_reg_next;
    key      <= key_next;
    idx      <= idx_next;
    rd_idx   <= rd_idx_next;
    pos      <= pos_next;
    status   <= status_next;
    rsp_data <= rsp_data_next;
  end

  // Entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_leaves_wait: assert property (@(posedge clk) disable iff (rst)
    accept |=> pc != S_WAIT)
    else $error("sequencer stayed in wait after taking a command");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (uc.op == OP_INSERT && !full) |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    hit |-> CNT_W'(rd_idx) < count)
    else $error("match reported beyond the entry count");

  a_result_from_post: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(pc) == S_POST)
    else $error("result loaded outside the post step");

endmodule

// ===== dv/unordered_list_table_tb.sv =====
// Self-checking testbench for unordered_list_table: directed and random command
// traffic against a shadow copy of the list, with random idling on both channels.
// Depends on ult_pkg, ult_stream_if and the RTL of unordered_list_table.
module unordered_list_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ult_pkg::*;

  localparam int CAPACITY = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;  // spare code, block answers not found
  localparam int RANDOM_ITEMS = 800;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 30;

  logic clk;
  logic rst;

  ult_stream_if #(.payload_t(cmd_t)) cmd_ch ();
  ult_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  unordered_list_table #(.CAPACITY(CAPACITY)) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the list and the results it predicts
  logic [31:0] shadow_words [CAPACITY];
  int unsigned shadow_count;
  rsp_t        pending_results [$];

  int unsigned cmds_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned status_seen [4];
  bit          gaps_on;
  int unsigned hold_off_left;
  bit          filling;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one command to the shadow list and return the expected result
  function automatic rsp_t apply_to_shadow(input logic [1:0] op, input logic [31:0] word);
    rsp_t r;
    int   hit;
    int   i;
    r.status   = ST_NOTFOUND;
    r.position = '0;
    hit = -1;
    // first bit-exact match among the valid entries only
    for (i = 0; i < int'(shadow_count); i++)
      if (hit < 0 && shadow_words[i] == word) hit = i;
    case (op)
      CMD_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[shadow_count] = word;
          r.position = POS_W'(shadow_count);
          shadow_count++;
          r.status = ST_OK;
        end
      end
      CMD_SEARCH: begin
        if (hit >= 0) begin
          r.status   = ST_OK;
          r.position = POS_W'(hit);
        end
      end
      CMD_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (hit >= 0) begin
          // last entry fills the vacated slot
          shadow_words[hit] = shadow_words[shadow_count - 1];
          shadow_count--;
          r.status   = ST_OK;
          r.position = POS_W'(hit);
        end
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(shadow_count);
    return r;
  endfunction

  // Idle stretch: mostly short, now and then long
  function automatic int unsigned idle_len();
    if ($urandom_range(99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Values that sit on the edges of the 32-bit word
  function automatic logic [31:0] pool_word(input int unsigned idx);
    case (idx)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h5555_5555;
      5: return 32'hAAAA_AAAA;
      6: return 32'h0000_0001;
      default: return 32'h8000_0001;
    endcase
  endfunction

  // Key for search or remove: mostly one that is present
  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (shadow_count > 0 && r < 60) return shadow_words[$urandom_range(shadow_count - 1)];
    if (r < 85) return pool_word($urandom_range(7));
    return $urandom();
  endfunction

  // Command mix swings between filling the list and draining it
  function automatic logic [1:0] pick_command();
    int unsigned r;
    if (filling && shadow_count == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
    else if (!filling && shadow_count == 0 && $urandom_range(3) == 0) filling = 1'b1;
    else if ($urandom_range(49) == 0) filling = !filling;
    r = $urandom_range(99);
    if (r < 2) return CMD_UNUSED;
    if (r < 25) return CMD_SEARCH;
    if (filling) return (r < 80) ? CMD_INSERT : CMD_REMOVE;
    return (r < 80) ? CMD_REMOVE : CMD_INSERT;
  endfunction

  // Offer one command, wait for the transaction, record the expected result
  task automatic send_cmd(input logic [1:0] op, input logic [31:0] word);
    cmd_t item;
    item.command = op;
    item.value   = word;
    cmd_ch.valid   <= 1'b1;
    cmd_ch.payload <= item;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    pending_results.push_back(apply_to_shadow(op, word));
    cmds_sent++;
    if (gaps_on && $urandom_range(1) == 1) begin
      cmd_ch.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic wait_for_results();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_random();
    logic [1:0] op;
    op = pick_command();
    if (op == CMD_INSERT && $urandom_range(1) == 0) send_cmd(op, $urandom());
    else send_cmd(op, pick_key());
  endtask

  // Empty-list answers, edge values, duplicates, swap on remove, spare code
  task automatic test_basic_commands();
    send_cmd(CMD_SEARCH, 32'h0000_0000);
    send_cmd(CMD_REMOVE, 32'h0000_0000);
    send_cmd(CMD_UNUSED, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 32'h8000_0000);
    send_cmd(CMD_INSERT, 32'h7FFF_FFFF);
    send_cmd(CMD_INSERT, 32'h0000_0000);
    send_cmd(CMD_INSERT, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 32'h7FFF_FFFF);   // duplicate, search must give the first
    send_cmd(CMD_SEARCH, 32'h7FFF_FFFF);
    send_cmd(CMD_SEARCH, 32'hFFFF_FFFF);
    send_cmd(CMD_SEARCH, 32'h1234_5678);   // absent
    send_cmd(CMD_REMOVE, 32'h8000_0000);   // head removed, tail moves in
    send_cmd(CMD_REMOVE, 32'hFFFF_FFFF);   // tail entry removed onto itself
    send_cmd(CMD_REMOVE, 32'h5555_AAAA);   // absent
    send_cmd(CMD_UNUSED, 32'h7FFF_FFFF);
  endtask

  // Fill to capacity, insert when full, work on the first and last slots
  task automatic test_full_list();
    while (shadow_count < CAPACITY) send_cmd(CMD_INSERT, 32'hA5A5_0000 | shadow_count);
    send_cmd(CMD_INSERT, 32'h0BAD_0BAD);
    send_cmd(CMD_SEARCH, shadow_words[CAPACITY - 1]);
    send_cmd(CMD_REMOVE, shadow_words[0]);
    send_cmd(CMD_REMOVE, shadow_words[shadow_count - 1]);
    send_cmd(CMD_INSERT, 32'h5555_5555);
  endtask

  // Receiver holds off for a long stretch while commands keep coming
  task automatic test_hold_off();
    gaps_on = 1'b0;
    hold_off_left = HOLD_OFF_CYCLES;
    repeat (12) send_random();
    gaps_on = 1'b1;
  endtask

  // Sender pauses until the block has answered everything
  task automatic test_pause();
    repeat (20) send_random();
    wait_for_results();
    repeat (20) send_random();
  endtask

  // Long random run, with a stretch without idling every few hundred commands
  task automatic test_random_traffic();
    int n;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) gaps_on = ((n / 100) % 4) != 3;
      send_random();
    end
    gaps_on = 1'b1;
  endtask

  // Result ready: random stalls, or a long hold-off when one is requested
  initial begin : result_ready
    int unsigned stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!gaps_on || $urandom_range(99) < 75) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        stall_left = idle_len() - 1;
        rsp_ch.ready <= 1'b0;
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    rsp_t want;
    rsp_t got;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got = rsp_ch.payload;
      results_seen++;
      status_seen[got.status]++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: status %0d position %0d count %0d",
                 $time, got.status, got.position, got.count);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
        if (got.position !== want.position) begin
          mismatches++;
          $display("%0t: position expected %0d actual %0d",
                   $time, want.position, got.position);
        end
        if (got.count !== want.count) begin
          mismatches++;
          $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
        end
      end
    end
  end

  // Test sequence
  initial begin
    shadow_count  = 0;
    cmds_sent     = 0;
    results_seen  = 0;
    mismatches    = 0;
    status_seen   = '{default: 0};
    gaps_on       = 1'b1;
    hold_off_left = 0;
    filling       = 1'b1;
    rst            <= 1'b1;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.payload <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_commands();
    test_full_list();
    test_hold_off();
    test_pause();
    test_random_traffic();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d commands, %0d results checked, %0d field mismatches",
             cmds_sent, results_seen, mismatches);
    $display("Statuses seen: ok %0d, full %0d, empty %0d, not found %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_NOTFOUND]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("unordered_list_table_tb OK");
    end else begin
      $display("unordered_list_table_tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("unordered_list_table_tb NOT OK");
    $finish;
  end

endmodule

// ===== unordered_list_table.f =====
rtl/ult_pkg.sv
rtl/ult_stream_if.sv
rtl/unordered_list_table.sv
dv/unordered_list_table_tb.sv
